### rtl/plii_pkg.sv
// Shared types, widths and helpers for the piecewise linear interpolator.
`default_nettype none

package plii_pkg;

  localparam int unsigned DataW        = 32;
  localparam int unsigned AluW         = DataW + 2;
  localparam int unsigned MaxPointsDef = 64;
  localparam int unsigned PointsW      = 7;
  localparam int unsigned LoadIdxW     = 6;
  localparam int unsigned CfgIdxW      = 1;

  localparam logic [PointsW-1:0] PointsRst = PointsW'(2);

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POINTS  = 1'b0,
    CFG_DEFAULT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic [LoadIdxW-1:0]      load_index;
    logic signed [DataW-1:0]  x_value;
    logic signed [DataW-1:0]  y_value;
    logic                     last_query;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0]  y_out;
    logic                     in_range;
    logic                     last_result;
  } out_item_t;

  function automatic logic [AluW-1:0] sext_alu(input logic [DataW-1:0] v);
    return {{(AluW-DataW){v[DataW-1]}}, v};
  endfunction

  function automatic logic [AluW-1:0] zext_alu(input logic [DataW-1:0] v);
    return {{(AluW-DataW){1'b0}}, v};
  endfunction

endpackage

`default_nettype wire

### rtl/piecewise_linear_interpolator_unit.sv
// Top level: configuration registers, item intake and result register.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------
//   in      | input     | in_valid/in_ready   | in_item_i  (load or query)
//   out     | output    | out_valid/out_ready | out_item_o (one per query)
//   cfg     | input     | cfg_valid/cfg_ready | cfg_index_i, cfg_data_i
//
// A load gives no result and leaves the block ready for the next item. A query
// first checks the range; then the scan reads one breakpoint per cycle from the
// table memory, and the single shared adder runs DataW multiply steps and DataW
// divide steps.
// Reset clears control state and sets points_in_use to 2, default to 0.
// A finished result waits in the output register; the block takes the next
// item while it waits, and stalls in its final state only if that register is full.
`default_nettype none

module piecewise_linear_interpolator_unit import plii_pkg::*; #(
  parameter int unsigned MaxPoints = MaxPointsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DataW-1:0]   cfg_data_i
);

  localparam int unsigned IdxW = $clog2(MaxPoints);

  logic [PointsW-1:0] points_q;
  logic [DataW-1:0]   default_q;
  logic [IdxW-1:0]    n_last;
  logic               idle, accept, wr_en, start;
  logic               res_valid, res_ready;
  out_item_t          res;
  logic               out_valid_q;
  out_item_t          out_item_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q  <= PointsRst;
      default_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_POINTS:  points_q  <= cfg_data_i[PointsW-1:0];
        CFG_DEFAULT: default_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the point count to the table and keep at least one segment.
  always_comb begin
    if (points_q < PointsW'(2)) begin
      n_last = IdxW'(1);
    end else if (int'(points_q) > MaxPoints) begin
      n_last = IdxW'(MaxPoints - 1);
    end else begin
      n_last = IdxW'(points_q - PointsW'(1));
    end
  end

  assign in_ready_o = idle;
  assign accept     = in_valid_i && idle;
  assign wr_en      = accept && (in_item_i.cmd == CMD_LOAD)
                      && (int'(in_item_i.load_index) < MaxPoints);
  assign start      = accept && (in_item_i.cmd == CMD_QUERY);

  plii_seq #(
    .MaxPoints (MaxPoints)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .wr_en_i      (wr_en),
    .wr_addr_i    (IdxW'(in_item_i.load_index)),
    .wr_x_i       (in_item_i.x_value),
    .wr_y_i       (in_item_i.y_value),
    .query_x_i    (in_item_i.x_value),
    .query_last_i (in_item_i.last_query),
    .n_last_i     (n_last),
    .default_i    (default_q),
    .idle_o       (idle),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

### rtl/plii_alu.sv
// Shared adder/subtractor used for every compare, difference and step.
`default_nettype none

module plii_alu import plii_pkg::*; (
  input  logic [AluW-1:0] a_i,
  input  logic [AluW-1:0] b_i,
  input  alu_op_e         op_i,
  output logic [AluW-1:0] sum_o
);

  always_comb begin
    unique case (op_i)
      ALU_ADD: sum_o = a_i + b_i;
      ALU_SUB: sum_o = a_i - b_i;
      default: sum_o = a_i + b_i;
    endcase
  end

endmodule

`default_nettype wire

### rtl/plii_seq.sv
// Sequencer with breakpoint memories: range check, scan, shift-add multiply, divide.
`default_nettype none

module plii_seq import plii_pkg::*; #(
  parameter  int unsigned MaxPoints = MaxPointsDef,
  localparam int unsigned IdxW      = $clog2(MaxPoints)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             wr_en_i,
  input  logic [IdxW-1:0]  wr_addr_i,
  input  logic [DataW-1:0] wr_x_i,
  input  logic [DataW-1:0] wr_y_i,
  input  logic [DataW-1:0] query_x_i,
  input  logic             query_last_i,
  input  logic [IdxW-1:0]  n_last_i,
  input  logic [DataW-1:0] default_i,
  output logic             idle_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output out_item_t        res_o
);

  localparam int unsigned CntW = $clog2(DataW);
  localparam logic [CntW-1:0] CntLast = CntW'(DataW - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHK_LO, ST_CHK_HI, ST_PREV, ST_SCAN, ST_DEN, ST_NUM,
    ST_DY, ST_NEG, ST_MUL, ST_DIV, ST_ADD, ST_DONE
  } state_e;

  state_e state_q;

  logic [DataW-1:0] mem_x [MaxPoints];
  logic [DataW-1:0] mem_y [MaxPoints];
  logic [DataW-1:0] rd_x_q, rd_y_q;
  logic [IdxW-1:0]  rd_addr;

  logic [DataW-1:0] xq_q, prev_x_q, prev_y_q, cur_x_q, cur_y_q;
  logic [DataW-1:0] hi_q, lo_q, den_q;
  logic [IdxW-1:0]  j_q;
  logic [CntW-1:0]  cnt_q;
  logic             last_q, neg_q, den_bad_q;
  logic [DataW-1:0] res_y_q;
  logic             res_inr_q;

  logic [AluW-1:0]  alu_a, alu_b, alu_sum;
  alu_op_e          alu_op;
  logic             alu_neg, alu_zero, found;

  plii_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .op_i  (alu_op),
    .sum_o (alu_sum)
  );

  assign alu_neg  = alu_sum[AluW-1];
  assign alu_zero = (alu_sum == '0);
  assign found    = !alu_neg || (j_q == n_last_i);

  // Table storage, one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_x[wr_addr_i] <= wr_x_i;
      mem_y[wr_addr_i] <= wr_y_i;
    end
    rd_x_q <= mem_x[rd_addr];
    rd_y_q <= mem_y[rd_addr];
  end

  always_comb begin
    rd_addr = '0;
    alu_a   = '0;
    alu_b   = '0;
    alu_op  = ALU_SUB;
    unique case (state_q)
      ST_CHK_LO: begin
        alu_a   = sext_alu(xq_q);
        alu_b   = sext_alu(rd_x_q);
        rd_addr = n_last_i;
      end
      ST_CHK_HI: begin
        alu_a = sext_alu(rd_x_q);
        alu_b = sext_alu(xq_q);
      end
      ST_PREV: rd_addr = IdxW'(1);
      ST_SCAN: begin
        alu_a   = sext_alu(rd_x_q);
        alu_b   = sext_alu(xq_q);
        rd_addr = j_q + IdxW'(1);
      end
      ST_DEN: begin
        alu_a = sext_alu(cur_x_q);
        alu_b = sext_alu(prev_x_q);
      end
      ST_NUM: begin
        alu_a = sext_alu(xq_q);
        alu_b = sext_alu(prev_x_q);
      end
      ST_DY: begin
        alu_a = sext_alu(cur_y_q);
        alu_b = sext_alu(prev_y_q);
      end
      ST_NEG: begin
        alu_a = sext_alu(prev_y_q);
        alu_b = sext_alu(cur_y_q);
      end
      ST_MUL: begin
        alu_op = ALU_ADD;
        alu_a  = zext_alu(hi_q);
        alu_b  = lo_q[0] ? zext_alu(den_q) : '0;
      end
      ST_DIV: begin
        alu_a = {{(AluW-DataW-1){1'b0}}, hi_q, lo_q[DataW-1]};
        alu_b = zext_alu(den_q);
      end
      ST_ADD: begin
        alu_op = neg_q ? ALU_SUB : ALU_ADD;
        alu_a  = sext_alu(prev_y_q);
        alu_b  = zext_alu(lo_q);
      end
      default: ;
    endcase
  end

  // State and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      res_y_q   <= '0;
      res_inr_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: if (start_i) state_q <= ST_CHK_LO;
        ST_CHK_LO: begin
          if (alu_neg) begin
            res_y_q   <= default_i;
            res_inr_q <= 1'b0;
            state_q   <= ST_DONE;
          end else begin
            state_q <= ST_CHK_HI;
          end
        end
        ST_CHK_HI: begin
          if (alu_neg) begin
            res_y_q   <= default_i;
            res_inr_q <= 1'b0;
            state_q   <= ST_DONE;
          end else begin
            state_q <= ST_PREV;
          end
        end
        ST_PREV: state_q <= ST_SCAN;
        ST_SCAN: if (found) state_q <= ST_DEN;
        ST_DEN:  state_q <= ST_NUM;
        ST_NUM: begin
          res_inr_q <= 1'b1;
          // Empty or reversed segment, or query at or below the lower point: take the lower y.
          if (den_bad_q || alu_neg || alu_zero) begin
            res_y_q <= prev_y_q;
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_DY;
          end
        end
        ST_DY:  state_q <= alu_neg ? ST_NEG : ST_MUL;
        ST_NEG: state_q <= ST_MUL;
        ST_MUL: if (cnt_q == CntLast) state_q <= ST_DIV;
        ST_DIV: if (cnt_q == CntLast) state_q <= ST_ADD;
        ST_ADD: begin
          res_y_q <= alu_sum[DataW-1:0];
          state_q <= ST_DONE;
        end
        ST_DONE: if (res_ready_i) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers; den_q holds the segment width, then the multiplicand, then the width again as divisor.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          xq_q   <= query_x_i;
          last_q <= query_last_i;
        end
      end
      ST_PREV: begin
        prev_x_q <= rd_x_q;
        prev_y_q <= rd_y_q;
        j_q      <= IdxW'(1);
      end
      ST_SCAN: begin
        if (found) begin
          cur_x_q <= rd_x_q;
          cur_y_q <= rd_y_q;
        end else begin
          prev_x_q <= rd_x_q;
          prev_y_q <= rd_y_q;
          j_q      <= j_q + IdxW'(1);
        end
      end
      ST_DEN: begin
        den_q     <= alu_sum[DataW-1:0];
        den_bad_q <= alu_neg || alu_zero;
      end
      ST_NUM: begin
        // Swap: lo holds the numerator until the magnitude of dy replaces it.
        lo_q <= alu_sum[DataW-1:0];
        hi_q <= den_q;
      end
      ST_DY: begin
        neg_q <= alu_neg;
        den_q <= lo_q;
        lo_q  <= alu_sum[DataW-1:0];
        cnt_q <= '0;
      end
      ST_NEG: lo_q <= alu_sum[DataW-1:0];
      ST_MUL: begin
        // Hold the divisor in cur_x while the product builds in hi:lo.
        if (cnt_q == '0) begin
          cur_x_q <= hi_q;
        end
        hi_q  <= (cnt_q == '0) ? (lo_q[0] ? den_q : '0) >> 1 : alu_sum[DataW:1];
        lo_q  <= (cnt_q == '0) ? {lo_q[0] & den_q[0], lo_q[DataW-1:1]}
                               : {alu_sum[0], lo_q[DataW-1:1]};
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntLast) begin
          den_q <= cur_x_q;
        end
      end
      ST_DIV: begin
        hi_q  <= alu_neg ? {hi_q[DataW-2:0], lo_q[DataW-1]} : alu_sum[DataW-1:0];
        lo_q  <= {lo_q[DataW-2:0], !alu_neg};
        cnt_q <= cnt_q + CntW'(1);
      end
      default: ;
    endcase
  end

  assign idle_o            = (state_q == ST_IDLE);
  assign res_valid_o       = (state_q == ST_DONE);
  assign res_o.y_out       = res_y_q;
  assign res_o.in_range    = res_inr_q;
  assign res_o.last_result = last_q;

endmodule

`default_nettype wire

### rtl/plii_checker.sv
// Port-level checks for the interpolator, bound to the top level.
`default_nettype none

module plii_port_checks import plii_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // Hold a result until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result dropped or changed while stalled");

  // The output register is empty after reset has been sampled.
  a_rst_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.cmd == CMD_QUERY) |=> !in_ready_o)
    else $error("query did not occupy the block");

  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.cmd == CMD_LOAD) |=> in_ready_o)
    else $error("load did not finish in one cycle");

  a_new_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without a query in flight");

endmodule

bind piecewise_linear_interpolator_unit plii_port_checks u_plii_port_checks (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

### dv/plii_checker.sv
// Checker for the interpolator: watches all channels, predicts each query result and compares.
`timescale 1ns / 1ps

module plii_checker import plii_pkg::*; #(
  parameter int unsigned MaxPoints = MaxPointsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  in_item_t           in_item_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  out_item_t          out_item_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DataW-1:0]   cfg_data_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);

  logic signed [DataW-1:0] bp_x [MaxPoints];
  logic signed [DataW-1:0] bp_y [MaxPoints];
  logic [PointsW-1:0]      points_q;
  logic signed [DataW-1:0] default_q;
  out_item_t               result_q [$];
  int unsigned             mismatches;

  assign fail_count_o = mismatches;

  function automatic out_item_t interpolate(input logic signed [DataW-1:0] xq,
                                            input logic last);
    int unsigned       n;
    int unsigned       j;
    bit                hit;
    longint            x0;
    longint            y0;
    longint            run;
    longint            span;
    longint            rise;
    longint unsigned   mag;
    longint            frac;
    out_item_t         r;
    n = points_q;
    if (n < 2) n = 2;
    if (n > MaxPoints) n = MaxPoints;
    r.last_result = last;
    if (xq < bp_x[0] || xq > bp_x[n-1]) begin
      r.y_out    = default_q;
      r.in_range = 1'b0;
      return r;
    end
    r.in_range = 1'b1;
    r.y_out    = bp_y[n-1];
    hit        = 1'b0;
    for (j = 1; j < n && !hit; j++) begin
      if (xq <= bp_x[j]) begin
        hit  = 1'b1;
        x0   = bp_x[j-1];
        y0   = bp_y[j-1];
        span = longint'(bp_x[j]) - x0;
        run  = longint'(xq) - x0;
        rise = longint'(bp_y[j]) - y0;
        if (span <= 0 || run <= 0) begin
          r.y_out = DataW'(y0);
        end else begin
          mag  = (rise < 0) ? $unsigned(-rise) : $unsigned(rise);
          // full-width product first, truncate toward zero on the divide
          frac = longint'(($unsigned(run) * mag) / $unsigned(span));
          r.y_out = DataW'((rise < 0) ? y0 - frac : y0 + frac);
        end
      end
    end
    return r;
  endfunction

  task automatic flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: mismatch: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      points_q   = PointsRst;
      default_q  = '0;
      mismatches = 0;
      result_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_POINTS:  points_q = cfg_data_i[PointsW-1:0];
          CFG_DEFAULT: default_q = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          flag($sformatf("unexpected result y_out %h in_range %b last %b",
                         out_item_i.y_out, out_item_i.in_range, out_item_i.last_result));
        end else begin
          want = result_q.pop_front();
          if (out_item_i.y_out !== want.y_out)
            flag($sformatf("y_out: expected %h, got %h", want.y_out, out_item_i.y_out));
          if (out_item_i.in_range !== want.in_range)
            flag($sformatf("in_range: expected %b, got %b",
                           want.in_range, out_item_i.in_range));
          if (out_item_i.last_result !== want.last_result)
            flag($sformatf("last_result: expected %b, got %b",
                           want.last_result, out_item_i.last_result));
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_item_i.cmd == CMD_LOAD) begin
          if (in_item_i.load_index < MaxPoints) begin
            bp_x[in_item_i.load_index] = in_item_i.x_value;
            bp_y[in_item_i.load_index] = in_item_i.y_value;
          end
        end else begin
          result_q.push_back(interpolate(in_item_i.x_value, in_item_i.last_query));
        end
      end
      pending_o <= result_q.size();
    end
  end

endmodule

### dv/tb_piecewise_linear_interpolator_unit.sv
// Testbench top: clock, reset, stimulus and verdict for the interpolator unit.
`timescale 1ns / 1ps

module tb_piecewise_linear_interpolator_unit;
  import plii_pkg::*;

  localparam int unsigned Drain      = 150;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned ItemGoal   = 1700;
  localparam logic [DataW-1:0] MinWord = {1'b1, {(DataW-1){1'b0}}};
  localparam logic [DataW-1:0] MaxWord = ~MinWord;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_item_t           in_item   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [DataW-1:0]   cfg_data  = '0;
  int unsigned        fail_count;
  int unsigned        pending;

  bit                 steady  = 1'b0;
  bit                 hold_go = 1'b0;
  int unsigned        sent    = 0;
  logic signed [DataW-1:0] tbl_x [MaxPointsDef];

  always #5 clk = ~clk;

  piecewise_linear_interpolator_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  plii_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic logic [DataW-1:0] pick_word();
    case ($urandom_range(9))
      0:       return MinWord;
      1:       return MaxWord;
      default: return $urandom;
    endcase
  endfunction

  // Mostly inside a segment of the table in use; some at its points, just past its ends or random.
  function automatic logic [DataW-1:0] pick_query_x(input int unsigned n);
    int unsigned k;
    longint      lo;
    longint      hi;
    longint      t;
    k = $urandom_range(n - 1, 1);
    case ($urandom_range(9))
      0, 1: return pick_word();
      2:    return tbl_x[$urandom_range(n - 1)];
      3:    return tbl_x[0] - 1;
      4:    return tbl_x[n-1] + 1;
      default: begin
        lo = tbl_x[k-1];
        hi = tbl_x[k];
        if (lo > hi) begin
          t  = lo;
          lo = hi;
          hi = t;
        end
        return DataW'(lo + longint'($urandom) % (hi - lo + 1));
      end
    endcase
  endfunction

  // Keep valid high across back-to-back items; drop it only in a gap.
  task automatic offer_item(input in_item_t item);
    while (!steady && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic load_point(input logic [LoadIdxW-1:0] idx, input logic [DataW-1:0] x,
                            input logic [DataW-1:0] y, input logic last);
    in_item_t item;
    item.cmd        = CMD_LOAD;
    item.load_index = idx;
    item.x_value    = x;
    item.y_value    = y;
    item.last_query = last;
    tbl_x[idx]      = x;
    offer_item(item);
  endtask

  task automatic query_at(input logic [DataW-1:0] x, input logic last);
    in_item_t item;
    item.cmd        = CMD_QUERY;
    item.load_index = LoadIdxW'($urandom);
    item.x_value    = x;
    item.y_value    = $urandom;
    item.last_query = last;
    offer_item(item);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (Drain) @(posedge clk);
  endtask

  task automatic set_registers(input logic [PointsW-1:0] pts, input logic [DataW-1:0] dflt);
    logic [DataW-1:0] upper;
    upper     = $urandom;
    cfg_valid <= 1'b1;
    cfg_index <= CFG_POINTS;
    cfg_data  <= {upper[DataW-1:PointsW], pts};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_DEFAULT;
    cfg_data  <= dflt;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Load entries 0..n-1, sorted unless asked otherwise; spread 0 means full range.
  task automatic build_table(input int unsigned n, input bit ordered,
                             input int unsigned spread);
    int          xs [MaxPointsDef];
    int          v;
    int          base;
    int unsigned k;
    int unsigned rot;
    base = $signed($urandom) >>> 1;
    rot  = $urandom_range(n - 1);
    for (int unsigned i = 0; i < n; i++) begin
      v = (spread == 0) ? $signed($urandom) : base + int'($urandom_range(spread));
      k = i;
      if (ordered) begin
        while (k > 0 && xs[k-1] > v) begin
          xs[k] = xs[k-1];
          k--;
        end
      end
      xs[k] = v;
    end
    for (int unsigned i = 0; i < n; i++) begin
      k = (i + rot) % n;
      load_point(LoadIdxW'(k), xs[k], pick_word(), 1'($urandom_range(1)));
    end
  endtask

  // Receiver: random stalls, one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 38);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAIL piecewise_linear_interpolator_unit");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned pts;
    int unsigned n;
    int unsigned spread;
    int unsigned queries;
    phase = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // full-range segment with falling y
    set_registers(PointsW'(2), MinWord);
    load_point(LoadIdxW'(0), MinWord, MaxWord, 1'b0);
    load_point(LoadIdxW'(1), MaxWord, MinWord, 1'b1);
    query_at(MinWord, 1'b0);
    query_at(MaxWord, 1'b0);
    query_at(DataW'(0), 1'b0);
    query_at(DataW'(-1), 1'b1);
    query_at(DataW'(1), 1'b0);
    // zero-width segment, then just outside it on both sides
    load_point(LoadIdxW'(0), DataW'(100), DataW'(7), 1'b0);
    load_point(LoadIdxW'(1), DataW'(100), DataW'(-9), 1'b0);
    query_at(DataW'(100), 1'b1);
    query_at(DataW'(99), 1'b0);
    query_at(DataW'(101), 1'b0);
    load_point(LoadIdxW'(63), MaxWord, DataW'(32'h5555_5555), 1'b1);
    // truncation toward zero, falling then rising
    load_point(LoadIdxW'(0), DataW'(0), DataW'(0), 1'b0);
    load_point(LoadIdxW'(1), DataW'(3), DataW'(-10), 1'b0);
    query_at(DataW'(1), 1'b0);
    query_at(DataW'(2), 1'b1);
    load_point(LoadIdxW'(1), DataW'(3), DataW'(10), 1'b0);
    query_at(DataW'(2), 1'b0);
    drain_block();
    // point counts below two act as two
    set_registers(PointsW'(0), MaxWord);
    query_at(DataW'(1), 1'b0);
    query_at(DataW'(-1), 1'b1);
    drain_block();
    set_registers(PointsW'(1), pick_word());
    query_at(DataW'(3), 1'b0);
    query_at(DataW'(4), 1'b1);

    while (sent < ItemGoal) begin
      drain_block();
      case ($urandom_range(9))
        7, 8:    pts = $urandom_range(32, 9);
        9:       pts = $urandom_range(1) ? MaxPointsDef : $urandom_range(127, 65);
        default: pts = $urandom_range(8, 2);
      endcase
      if (phase % 7 == 6) pts = $urandom_range(1);
      n = pts;
      if (n < 2) n = 2;
      if (n > MaxPointsDef) n = MaxPointsDef;
      set_registers(PointsW'(pts), pick_word());
      steady = (phase == 4);
      if (phase == 2) hold_go = 1'b1;
      case ($urandom_range(3))
        0:       spread = 0;
        1:       spread = 16;
        default: spread = 1 << 20;
      endcase
      build_table(n, $urandom_range(6) != 0, spread);
      queries = $urandom_range(60, 20);
      repeat (queries) begin
        if ($urandom_range(19) == 0)
          load_point(LoadIdxW'($urandom), pick_word(), pick_word(),
                     1'($urandom_range(1)));
        else
          query_at(pick_query_x(n), $urandom_range(7) == 0);
      end
      query_at(pick_query_x(n), 1'b1);
      phase++;
    end
    steady = 1'b0;
    drain_block();

    if (fail_count == 0)
      $display("PASS piecewise_linear_interpolator_unit");
    else
      $display("FAIL piecewise_linear_interpolator_unit");
    $finish;
  end

endmodule

### files.f
rtl/plii_pkg.sv
rtl/plii_alu.sv
rtl/plii_seq.sv
rtl/piecewise_linear_interpolator_unit.sv
rtl/plii_checker.sv
dv/plii_checker.sv
dv/tb_piecewise_linear_interpolator_unit.sv
